// ===== sv/cpg_pkg.sv =====
// ============================================================================
// cpg_pkg
// Shared types and constants of the covariance point gate: word formats of
// both channels, the words passed between the pipeline sections, and the
// fixed-point widths of the datapath.
// ============================================================================
package cpg_pkg;

    localparam int Lanes      = 3;
    localparam int CoordW     = 32;
    localparam int EntryW     = 21;
    localparam int ColW       = 63;
    localparam int DiffW      = 33;
    localparam int ProdW      = 42;
    localparam int AdjW       = 43;
    localparam int SplitW     = 16;
    localparam int PartW      = 60;
    localparam int DetW       = 64;
    localparam int NumW       = 78;
    localparam int RemW       = 64;
    localparam int QuoW       = 24;
    localparam int VW         = 25;
    localparam int SqW        = 49;
    localparam int SumW       = 51;
    localparam int FracShift  = 16;
    localparam int ClampShift = 8;
    localparam int DistW      = 32;
    localparam int ThrW       = 34;
    localparam int DivSteps   = QuoW;

    localparam int FrontStages = 4;
    localparam int DivStages   = DivSteps + 1;
    localparam int BackStages  = 3;

    localparam logic [VW-1:0]         VClamp  = VW'(1) << QuoW;
    localparam logic signed [ThrW-1:0] ExpectQ = ThrW'(196608);

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic signed [CoordW-1:0] mean_x;
        logic signed [CoordW-1:0] mean_y;
        logic signed [CoordW-1:0] mean_z;
        logic [ColW-1:0]          cov_col_0;
        logic [ColW-1:0]          cov_col_1;
        logic [ColW-1:0]          cov_col_2;
    } t_in;

    typedef struct packed {
        logic             pass;
        logic             singular;
        logic [DistW-1:0] distance_sq;
    } t_out;

    typedef struct packed {
        logic signed [DetW-1:0]       det;
        logic [Lanes-1:0][NumW-1:0]   n;
    } t_front;

    typedef struct packed {
        logic                         sing;
        logic [Lanes-1:0]             clamp;
        logic [Lanes-1:0][QuoW-1:0]   q;
    } t_quo;

endpackage

// ===== sv/covariance_point_gate_unit.sv =====
// ============================================================================
// covariance_point_gate_unit
// Mahalanobis distance gate of a 3D point against a voxel mean and the
// square root S of the voxel covariance.
// ============================================================================
// The unit accepts one point word per clock while the input is not stalled
// and returns one result word per point in order. The front end forms the
// adjugate, determinant and numerators; a magnitude stage follows, then the
// pipelined restoring division that yields one quotient bit per stage, and
// the back end for squaring, saturation and the gate decision. The input is
// stalled only when every pipeline stage holds a word and the output is
// stalled. The tolerance register is written through its own port and
// should be changed only while no point is in flight.
module covariance_point_gate_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cpg_pkg::t_in               i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cpg_pkg::t_out              o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cpg_pkg::CoordW-1:0] i_cfg_data
);
    import cpg_pkg::*;

    logic signed [CoordW-1:0] r_tolerance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= -CoordW'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tolerance <= $signed(i_cfg_data);
        end
    end

    logic   w_f_valid;
    logic   w_f_stall;
    t_front w_f_word;
    logic   w_q_valid;
    logic   w_q_stall;
    t_quo   w_q_word;

    cpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_word  (i_in_word),
        .o_valid (w_f_valid),
        .i_stall (w_f_stall),
        .o_word  (w_f_word)
    );

    cpg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_f_stall),
        .i_word  (w_f_word),
        .o_valid (w_q_valid),
        .i_stall (w_q_stall),
        .o_word  (w_q_word)
    );

    cpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_stall     (w_q_stall),
        .i_word      (w_q_word),
        .i_tolerance (r_tolerance),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_word      (o_out_word)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("Input stalled while the output is not stalled.");

    a_singular_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.singular) |-> (o_out_word.distance_sq == '1))
        else $error("Singular result word without a saturated distance.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output word valid right after reset.");

endmodule

// ===== sv/cpg_front.sv =====
// ============================================================================
// cpg_front
// Four-stage front end: difference vector, adjugate of S, partial products,
// then determinant and the three numerators of inverse(S) * d.
// ============================================================================
module cpg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cpg_pkg::t_in   i_word,
    output logic           o_valid,
    input  logic           i_stall,
    output cpg_pkg::t_front o_word
);
    import cpg_pkg::*;

    function automatic logic signed [ProdW-1:0] mul_e(
        input logic signed [EntryW-1:0] a,
        input logic signed [EntryW-1:0] b
    );
        return ProdW'(a) * ProdW'(b);
    endfunction

    function automatic logic signed [DetW-1:0] mul_det(
        input logic signed [EntryW-1:0] a,
        input logic signed [AdjW-1:0]   b
    );
        return DetW'(a) * DetW'(b);
    endfunction

    function automatic logic signed [PartW-1:0] mul_part(
        input logic signed [AdjW-1:0]     a,
        input logic signed [SplitW:0]     b
    );
        return PartW'(a) * PartW'(b);
    endfunction

    logic [FrontStages-1:0] r_v;
    logic [FrontStages-1:0] w_load;

    assign w_load[FrontStages-1] = !r_v[FrontStages-1] || !i_stall;
    for (genvar k = 0; k < FrontStages - 1; k++) begin : g_load
        assign w_load[k] = !r_v[k] || w_load[k+1];
    end

    assign o_stall = !w_load[0];
    assign o_valid = r_v[FrontStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_load[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < FrontStages; k++) begin
                if (w_load[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic [ColW-1:0]            w_col [Lanes];
    logic signed [DiffW-1:0]    n_d   [Lanes];
    logic signed [EntryW-1:0]   n_m   [Lanes][Lanes];
    logic signed [DiffW-1:0]    r_d_a [Lanes];
    logic signed [EntryW-1:0]   r_m_a [Lanes][Lanes];

    always_comb begin
        w_col[0] = i_word.cov_col_0;
        w_col[1] = i_word.cov_col_1;
        w_col[2] = i_word.cov_col_2;
        n_d[0] = DiffW'(i_word.point_x) - DiffW'(i_word.mean_x);
        n_d[1] = DiffW'(i_word.point_y) - DiffW'(i_word.mean_y);
        n_d[2] = DiffW'(i_word.point_z) - DiffW'(i_word.mean_z);
        for (int r = 0; r < Lanes; r++) begin
            for (int c = 0; c < Lanes; c++) begin
                n_m[r][c] = $signed(w_col[c][r*EntryW +: EntryW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_d_a <= n_d;
            r_m_a <= n_m;
        end
    end

    logic signed [AdjW-1:0]     n_adj   [Lanes][Lanes];
    logic signed [AdjW-1:0]     r_adj_b [Lanes][Lanes];
    logic signed [EntryW-1:0]   r_m0_b  [Lanes];
    logic signed [DiffW-1:0]    r_d_b   [Lanes];

    always_comb begin
        n_adj[0][0] = AdjW'(mul_e(r_m_a[1][1], r_m_a[2][2])) - AdjW'(mul_e(r_m_a[1][2], r_m_a[2][1]));
        n_adj[0][1] = AdjW'(mul_e(r_m_a[0][2], r_m_a[2][1])) - AdjW'(mul_e(r_m_a[0][1], r_m_a[2][2]));
        n_adj[0][2] = AdjW'(mul_e(r_m_a[0][1], r_m_a[1][2])) - AdjW'(mul_e(r_m_a[0][2], r_m_a[1][1]));
        n_adj[1][0] = AdjW'(mul_e(r_m_a[1][2], r_m_a[2][0])) - AdjW'(mul_e(r_m_a[1][0], r_m_a[2][2]));
        n_adj[1][1] = AdjW'(mul_e(r_m_a[0][0], r_m_a[2][2])) - AdjW'(mul_e(r_m_a[0][2], r_m_a[2][0]));
        n_adj[1][2] = AdjW'(mul_e(r_m_a[0][2], r_m_a[1][0])) - AdjW'(mul_e(r_m_a[0][0], r_m_a[1][2]));
        n_adj[2][0] = AdjW'(mul_e(r_m_a[1][0], r_m_a[2][1])) - AdjW'(mul_e(r_m_a[1][1], r_m_a[2][0]));
        n_adj[2][1] = AdjW'(mul_e(r_m_a[0][1], r_m_a[2][0])) - AdjW'(mul_e(r_m_a[0][0], r_m_a[2][1]));
        n_adj[2][2] = AdjW'(mul_e(r_m_a[0][0], r_m_a[1][1])) - AdjW'(mul_e(r_m_a[0][1], r_m_a[1][0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r_adj_b <= n_adj;
            r_m0_b  <= r_m_a[0];
            r_d_b   <= r_d_a;
        end
    end

    logic signed [DetW-1:0]  r_dp_c  [Lanes];
    logic signed [PartW-1:0] r_plo_c [Lanes][Lanes];
    logic signed [PartW-1:0] r_phi_c [Lanes][Lanes];

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            for (int j = 0; j < Lanes; j++) begin
                r_dp_c[j] <= mul_det(r_m0_b[j], r_adj_b[j][0]);
                for (int i = 0; i < Lanes; i++) begin
                    r_plo_c[i][j] <= mul_part(r_adj_b[i][j],
                                              $signed({1'b0, r_d_b[j][SplitW-1:0]}));
                    r_phi_c[i][j] <= mul_part(r_adj_b[i][j],
                                              $signed(r_d_b[j][DiffW-1:SplitW]));
                end
            end
        end
    end

    logic signed [DetW-1:0] n_det;
    logic signed [NumW-1:0] n_num [Lanes];
    logic signed [DetW-1:0] r_det_d;
    logic signed [NumW-1:0] r_n_d [Lanes];

    always_comb begin
        n_det = r_dp_c[0] + r_dp_c[1] + r_dp_c[2];
        for (int i = 0; i < Lanes; i++) begin
            n_num[i] = '0;
            for (int j = 0; j < Lanes; j++) begin
                n_num[i] = n_num[i] + (NumW'(r_phi_c[i][j]) <<< SplitW) + NumW'(r_plo_c[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[3]) begin
            r_det_d <= n_det;
            r_n_d   <= n_num;
        end
    end

    always_comb begin
        o_word.det = r_det_d;
        for (int i = 0; i < Lanes; i++) begin
            o_word.n[i] = r_n_d[i];
        end
    end

endmodule

// ===== sv/cpg_divider.sv =====
// ============================================================================
// cpg_divider
// Magnitude stage, then one restoring quotient bit per stage for each of the
// three components of v, with the clamp test done in the first step.
// ============================================================================
module cpg_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cpg_pkg::t_front i_word,
    output logic            o_valid,
    input  logic            i_stall,
    output cpg_pkg::t_quo   o_word
);
    import cpg_pkg::*;

    logic [DivStages-1:0] r_v;
    logic [DivStages-1:0] w_load;

    assign w_load[DivStages-1] = !r_v[DivStages-1] || !i_stall;
    for (genvar k = 0; k < DivStages - 1; k++) begin : g_load
        assign w_load[k] = !r_v[k] || w_load[k+1];
    end

    assign o_stall = !w_load[0];
    assign o_valid = r_v[DivStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_load[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < DivStages; k++) begin
                if (w_load[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic [DetW-1:0]        r_den   [0:DivSteps];
    logic                   r_sing  [0:DivSteps];
    logic [NumW-1:0]        r_mag0  [Lanes];
    logic [RemW-1:0]        r_rem   [1:DivSteps][Lanes];
    logic [QuoW-1:0]        r_q     [1:DivSteps][Lanes];
    logic [ClampShift-1:0]  r_lo    [1:DivSteps][Lanes];
    logic [Lanes-1:0]       r_clamp [1:DivSteps];

    logic signed [NumW-1:0] w_ns  [Lanes];
    logic [NumW-1:0]        n_mag [Lanes];
    logic [DetW-1:0]        n_den;

    always_comb begin
        n_den = i_word.det[DetW-1] ? DetW'(-i_word.det) : DetW'(i_word.det);
        for (int l = 0; l < Lanes; l++) begin
            w_ns[l]  = $signed(i_word.n[l]);
            n_mag[l] = w_ns[l][NumW-1] ? NumW'(-w_ns[l]) : NumW'(w_ns[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_den[0]  <= n_den;
            r_sing[0] <= (i_word.det == '0);
            r_mag0    <= n_mag;
        end
    end

    for (genvar k = 1; k <= DivSteps; k++) begin : g_step
        localparam int Bit = DivSteps - k;

        logic [RemW-1:0]       w_rem_in [Lanes];
        logic [QuoW-1:0]       w_q_in   [Lanes];
        logic [ClampShift-1:0] w_lo_in  [Lanes];
        logic [Lanes-1:0]      w_clamp_in;
        logic [Lanes-1:0]      w_xbit;
        logic [RemW:0]         w_trial  [Lanes];
        logic [Lanes-1:0]      w_ge;

        if (k == 1) begin : g_first
            always_comb begin
                for (int l = 0; l < Lanes; l++) begin
                    w_rem_in[l]   = r_mag0[l][RemW+ClampShift-1:ClampShift];
                    w_q_in[l]     = '0;
                    w_lo_in[l]    = r_mag0[l][ClampShift-1:0];
                    w_clamp_in[l] = r_mag0[l] >= NumW'({r_den[0], {ClampShift{1'b0}}});
                end
            end
        end else begin : g_next
            always_comb begin
                w_clamp_in = r_clamp[k-1];
                for (int l = 0; l < Lanes; l++) begin
                    w_rem_in[l] = r_rem[k-1][l];
                    w_q_in[l]   = r_q[k-1][l];
                    w_lo_in[l]  = r_lo[k-1][l];
                end
            end
        end

        if (Bit >= FracShift) begin : g_data
            always_comb begin
                for (int l = 0; l < Lanes; l++) begin
                    w_xbit[l] = w_lo_in[l][Bit-FracShift];
                end
            end
        end else begin : g_zero
            assign w_xbit = '0;
        end

        always_comb begin
            for (int l = 0; l < Lanes; l++) begin
                w_trial[l] = {w_rem_in[l], w_xbit[l]};
                w_ge[l]    = w_trial[l] >= {1'b0, r_den[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_load[k]) begin
                r_den[k]   <= r_den[k-1];
                r_sing[k]  <= r_sing[k-1];
                r_clamp[k] <= w_clamp_in;
                for (int l = 0; l < Lanes; l++) begin
                    r_rem[k][l] <= w_ge[l] ? RemW'(w_trial[l] - {1'b0, r_den[k-1]})
                                           : w_trial[l][RemW-1:0];
                    r_q[k][l]   <= {w_q_in[l][QuoW-2:0], w_ge[l]};
                    r_lo[k][l]  <= w_lo_in[l];
                end
            end
        end
    end

    always_comb begin
        o_word.sing  = r_sing[DivSteps];
        o_word.clamp = r_clamp[DivSteps];
        for (int l = 0; l < Lanes; l++) begin
            o_word.q[l] = r_q[DivSteps][l];
        end
    end

endmodule

// ===== sv/cpg_back.sv =====
// ============================================================================
// cpg_back
// Squares the clamped components, sums and saturates the distance, and
// holds the result word in the output register with the gate decision.
// ============================================================================
module cpg_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  cpg_pkg::t_quo              i_word,
    input  logic signed [cpg_pkg::CoordW-1:0] i_tolerance,
    output logic                       o_valid,
    input  logic                       i_stall,
    output cpg_pkg::t_out              o_word
);
    import cpg_pkg::*;

    logic [BackStages-1:0] r_v;
    logic [BackStages-1:0] w_load;

    assign w_load[BackStages-1] = !r_v[BackStages-1] || !i_stall;
    for (genvar k = 0; k < BackStages - 1; k++) begin : g_load
        assign w_load[k] = !r_v[k] || w_load[k+1];
    end

    assign o_stall = !w_load[0];
    assign o_valid = r_v[BackStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_load[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < BackStages; k++) begin
                if (w_load[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic [VW-1:0]  w_v   [Lanes];
    logic [SqW-1:0] n_sq  [Lanes];
    logic [SqW-1:0] r_sq  [Lanes];
    logic           r_sing0;

    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            w_v[l]  = i_word.clamp[l] ? VClamp : VW'(i_word.q[l]);
            n_sq[l] = SqW'(w_v[l]) * SqW'(w_v[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_sq    <= n_sq;
            r_sing0 <= i_word.sing;
        end
    end

    logic [SumW-1:0]  w_sum;
    logic [SumW-FracShift-1:0] w_shr;
    logic [DistW-1:0] n_dist1;
    logic [DistW-1:0] r_dist1;
    logic             r_sing1;

    always_comb begin
        w_sum   = SumW'(r_sq[0]) + SumW'(r_sq[1]) + SumW'(r_sq[2]);
        w_shr   = w_sum[SumW-1:FracShift];
        n_dist1 = (|w_shr[SumW-FracShift-1:DistW]) ? '1 : w_shr[DistW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r_dist1 <= n_dist1;
            r_sing1 <= r_sing0;
        end
    end

    logic signed [ThrW-1:0] w_thr;
    logic [DistW-1:0]       w_dist;
    t_out                   n_out;
    t_out                   r_out;

    always_comb begin
        w_thr  = ExpectQ + ThrW'(i_tolerance);
        w_dist = r_sing1 ? '1 : r_dist1;
        n_out.singular    = r_sing1;
        n_out.distance_sq = w_dist;
        if (i_tolerance < 0) begin
            n_out.pass = 1'b1;
        end else if (r_sing1) begin
            n_out.pass = 1'b0;
        end else begin
            n_out.pass = $signed({2'b00, w_dist}) < w_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

// ===== test/covariance_point_gate_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// covariance_point_gate_unit_tb
// Self-checking testbench of the covariance point gate. Point words are sent
// under random idling and output stalls, a local predictor computes the
// expected gate result of each accepted word, and every result word is
// compared in order against it across several tolerance settings.
// ============================================================================
module covariance_point_gate_unit_tb;

    import cpg_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int DrainCycles = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    t_out        gate_queue[$];
    logic signed [31:0] tol_q;
    int          fail_count;
    int          idle_pct;
    int          stall_pct;
    bit          hold_out;
    int          quiet_cycles;

    covariance_point_gate_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic signed [63:0] entry_of(logic [62:0] col, int r);
        logic [20:0] e;
        e = col[21*r +: 21];
        return 64'(signed'(e));
    endfunction

    function automatic logic [63:0] scaled_quotient(logic signed [127:0] num,
                                                    logic [63:0] den);
        logic [127:0] m;
        logic [143:0] q;
        m = num < 0 ? 128'(-num) : 128'(num);
        q = {m, 16'd0} / 144'(den);
        if (q >= 144'(1 << 24)) return 64'(1 << 24);
        return q[63:0];
    endfunction

    function automatic t_out predict_gate(t_in w, logic signed [31:0] tol);
        logic signed [63:0] d[3];
        logic signed [63:0] m[3][3];
        logic signed [63:0] a[3][3];
        logic signed [63:0] det;
        logic signed [127:0] n;
        logic [63:0] den;
        logic [63:0] v;
        logic [63:0] sum;
        t_out o;
        d[0] = 64'(w.point_x) - 64'(w.mean_x);
        d[1] = 64'(w.point_y) - 64'(w.mean_y);
        d[2] = 64'(w.point_z) - 64'(w.mean_z);
        for (int r = 0; r < 3; r++) begin
            m[r][0] = entry_of(w.cov_col_0, r);
            m[r][1] = entry_of(w.cov_col_1, r);
            m[r][2] = entry_of(w.cov_col_2, r);
        end
        a[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
        a[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
        a[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
        a[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
        a[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
        a[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
        a[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
        a[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
        a[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
        det = m[0][0] * a[0][0] + m[0][1] * a[1][0] + m[0][2] * a[2][0];
        o.singular = (det == 0);
        o.distance_sq = 32'hFFFF_FFFF;
        if (!o.singular) begin
            den = det < 0 ? 64'(-det) : 64'(det);
            sum = 0;
            for (int r = 0; r < 3; r++) begin
                n = 128'(a[r][0]) * 128'(d[0]) + 128'(a[r][1]) * 128'(d[1])
                    + 128'(a[r][2]) * 128'(d[2]);
                v = scaled_quotient(n, den);
                sum = sum + v * v;
            end
            sum = sum >> 16;
            o.distance_sq = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (tol < 0) o.pass = 1'b1;
        else if (o.singular) o.pass = 1'b0;
        else o.pass = 64'(o.distance_sq) < 64'sd196608 + 64'(tol);
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gate_queue.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_out_word);
                fail_count++;
            end else begin
                exp_word = gate_queue.pop_front();
                if (o_out_word.pass !== exp_word.pass ||
                    o_out_word.singular !== exp_word.singular ||
                    o_out_word.distance_sq !== exp_word.distance_sq) begin
                    $display("%0t: mismatch expected %b %b %h actual %b %b %h", $time,
                             exp_word.pass, exp_word.singular, exp_word.distance_sq,
                             o_out_word.pass, o_out_word.singular,
                             o_out_word.distance_sq);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= hold_out || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_point(t_in w);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_word <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gate_queue.push_back(predict_gate(w, tol_q));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (gate_queue.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic signed [31:0] t);
        wait_drained();
        i_cfg_data <= t;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tol_q = t;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [62:0] diag_col(int r, logic [20:0] e);
        logic [62:0] c;
        c = '0;
        c[21*r +: 21] = e;
        return c;
    endfunction

    function automatic logic [20:0] rand_entry();
        case ($urandom_range(3))
            0: return 21'($urandom_range(131072) - 65536);
            1: return 21'($urandom);
            2: return 21'($urandom_range(4) == 0 ? 0 : $urandom_range(65536) + 4096);
            default: return 21'($urandom_range(2) == 0 ? 21'h100000 : 21'h0FFFFF);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return 32'($urandom_range(262144) - 131072);
            1: return $urandom;
            2: return 32'($urandom_range(65536 * 8) - 65536 * 4);
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_in rand_point();
        t_in w;
        logic [20:0] e[9];
        w.mean_x = rand_coord();
        w.mean_y = rand_coord();
        w.mean_z = rand_coord();
        w.point_x = $urandom_range(1) ? w.mean_x + 32'($urandom_range(400000) - 200000)
                                      : rand_coord();
        w.point_y = $urandom_range(1) ? w.mean_y + 32'($urandom_range(400000) - 200000)
                                      : rand_coord();
        w.point_z = $urandom_range(1) ? w.mean_z + 32'($urandom_range(400000) - 200000)
                                      : rand_coord();
        for (int i = 0; i < 9; i++) e[i] = rand_entry();
        if ($urandom_range(9) < 6) begin
            e[1] = $urandom_range(3) == 0 ? e[1] : 21'($urandom_range(4096) - 2048);
            e[2] = $urandom_range(3) == 0 ? e[2] : 21'($urandom_range(4096) - 2048);
            e[3] = $urandom_range(3) == 0 ? e[3] : 21'($urandom_range(4096) - 2048);
        end
        if ($urandom_range(19) == 0) begin
            e[6] = e[0];
            e[7] = e[1];
            e[8] = e[2];
        end
        w.cov_col_0 = {e[2], e[1], e[0]};
        w.cov_col_1 = {e[5], e[4], e[3]};
        w.cov_col_2 = {e[8], e[7], e[6]};
        return w;
    endfunction

    task automatic test_directed();
        t_in w;
        logic [20:0] one;
        one = 21'd65536;
        w.point_x = 0;
        w.point_y = 0;
        w.point_z = 0;
        w.mean_x = 0;
        w.mean_y = 0;
        w.mean_z = 0;
        w.cov_col_0 = diag_col(0, one);
        w.cov_col_1 = diag_col(1, one);
        w.cov_col_2 = diag_col(2, one);
        send_point(w);
        w.point_x = 32'sd65536;
        send_point(w);
        w.point_y = 32'sd65536;
        w.point_z = 32'sd65536;
        send_point(w);
        w.point_x = 32'h7FFF_FFFF;
        w.mean_x = 32'h8000_0000;
        send_point(w);
        w.point_x = 32'h8000_0000;
        w.mean_x = 32'h7FFF_FFFF;
        w.point_y = 32'h8000_0000;
        w.mean_z = 32'h7FFF_FFFF;
        send_point(w);
        w.cov_col_1 = '0;
        send_point(w);
        w.cov_col_0 = {3{21'h100000}};
        w.cov_col_1 = {21'h0FFFFF, 21'h100000, 21'h0FFFFF};
        w.cov_col_2 = {21'h100000, 21'h0FFFFF, 21'h0FFFFF};
        send_point(w);
        w.cov_col_0 = diag_col(0, 21'd1);
        w.cov_col_1 = diag_col(1, 21'd1);
        w.cov_col_2 = diag_col(2, 21'd1);
        send_point(w);
        w.point_x = 32'sd110000;
        w.point_y = 0;
        w.point_z = 0;
        w.mean_x = 0;
        w.mean_y = 0;
        w.mean_z = 0;
        w.cov_col_0 = diag_col(0, one);
        w.cov_col_1 = diag_col(1, one);
        w.cov_col_2 = diag_col(2, one);
        for (int t = 0; t < 4; t++) begin
            w.point_x = 32'sd113000 + 32'(t * 200);
            send_point(w);
        end
        w.cov_col_0 = diag_col(0, 21'h1F0000);
        w.cov_col_1 = {21'd300, 21'h1F0000, 21'd7};
        w.point_x = 32'sd1234567;
        send_point(w);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_point(rand_point());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_out = 1'b0;
            end
            test_random(120);
        join
        wait_drained();
        test_random(50);
    endtask

    initial begin
        fail_count = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_out = 1'b0;
        tol_q = -32'sd65536;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        write_tolerance(32'sd0);
        test_directed();
        write_tolerance(32'h7FFF_FFFF);
        test_random(150);
        write_tolerance(32'h8000_0000);
        idle_pct = 65;
        test_random(300);
        write_tolerance(32'sd32768);
        idle_pct = 0;
        stall_pct = 65;
        test_random(400);
        write_tolerance(32'sd196608);
        idle_pct = 17;
        stall_pct = 17;
        test_random(400);
        stall_pct = 0;
        idle_pct = 0;
        write_tolerance(32'sd65536);
        test_backpressure();
        write_tolerance(-32'sd1);
        test_random(200);
        write_tolerance(32'sd0);
        test_random(200);
        wait_drained();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
